FILE: sv/dshot_pkg.sv
// Package: constants and helper functions for the DShot frame pulse encoder.
`timescale 1ns / 1ps

package dshot_pkg;

   // Field widths
   localparam int THROTTLE_W   = 16;
   localparam int THR_CLAMP_W  = 11;
   localparam int MODE_W       = 3;
   localparam int PAUSE_W      = 15;
   localparam int HIGH_W       = 15;
   localparam int LOW_W        = 6;
   localparam int FRAME_BITS   = 16;
   localparam int CNT_W        = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 15;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_RATE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROTTLE_FLOOR   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROTTLE_CEILING = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE_TICKS      = 2'd3;

   // Rate mode codes
   localparam logic [MODE_W-1:0] MODE_150K  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_300K  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_600K  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_1200K = 3'd3;

   // Reset values of the registers
   localparam logic [MODE_W-1:0]      RESET_MODE     = MODE_600K;
   localparam logic [THR_CLAMP_W-1:0] RESET_FLOOR    = 11'd48;
   localparam logic [THR_CLAMP_W-1:0] RESET_CEILING  = 11'd2047;
   localparam logic [PAUSE_W-1:0]     RESET_PAUSE    = 15'd0;

   // Bit timing in ticks for one rate mode
   typedef struct packed {
      logic [6:0] period;
      logic [5:0] zero_high;
      logic [5:0] one_high;
   } timing_type;

   function automatic timing_type rate_timing(input logic [MODE_W-1:0] mode);
      timing_type t;
      unique case (mode)
         MODE_150K:  t = '{period: 7'd64, zero_high: 6'd24, one_high: 6'd48};
         MODE_300K:  t = '{period: 7'd32, zero_high: 6'd12, one_high: 6'd24};
         MODE_600K:  t = '{period: 7'd16, zero_high: 6'd6,  one_high: 6'd12};
         MODE_1200K: t = '{period: 7'd8,  zero_high: 6'd3,  one_high: 6'd6};
         default:    t = '{period: 7'd0,  zero_high: 6'd0,  one_high: 6'd0};
      endcase
      return t;
   endfunction

   // Clamp the throttle (floor first, ceiling wins) and build the 16-bit frame
   function automatic logic [FRAME_BITS-1:0] encode_frame(
      input logic [THROTTLE_W-1:0]  thr,
      input logic                   tel,
      input logic [THR_CLAMP_W-1:0] floor_val,
      input logic [THR_CLAMP_W-1:0] ceil_val
   );
      logic [THROTTLE_W-1:0]  t;
      logic [11:0]            word;
      logic [3:0]             chk;
      t = thr;
      if (t < {5'd0, floor_val}) t = {5'd0, floor_val};
      if (t > {5'd0, ceil_val})  t = {5'd0, ceil_val};
      word = {t[10:0], tel};
      chk  = word[11:8] ^ word[7:4] ^ word[3:0];
      return {word, chk};
   endfunction

endpackage

FILE: sv/dshot_frame_pulse_encoder_core.sv
// Top level: DShot frame pulse encoder, throttle transaction in, 17 pulse items out.
`timescale 1ns / 1ps

// Each accepted throttle transaction yields seventeen pulse items: sixteen
// data bits of the DShot frame, MSB first, each a high phase followed by a
// low phase, then one low pause item flagged with rsp_last. Items leave one
// per cycle through a registered output stage while rsp_stall is low;
// the next transaction is taken in the cycle its predecessor's pause item
// moves to the output, so frames follow each other with no gap on the
// output. The clamp and checksum are computed when a transaction is
// accepted and held in a frame shift register; the bit timing follows
// the live rate mode register. Registers must only be written while no
// frame is in flight.
module dshot_frame_pulse_encoder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write,
   input  logic [dshot_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dshot_pkg::CSR_DATA_W-1:0]      csr_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dshot_pkg::THROTTLE_W-1:0]      req_throttle,
   input  logic                                  req_telemetry_request,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_first_level,
   output logic [dshot_pkg::HIGH_W-1:0]          rsp_first_duration,
   output logic                                  rsp_second_level,
   output logic [dshot_pkg::LOW_W-1:0]           rsp_second_duration,
   output logic                                  rsp_last
);

   // Configuration registers
   logic [dshot_pkg::MODE_W-1:0]      mode_ff;
   logic [dshot_pkg::THR_CLAMP_W-1:0] floor_ff;
   logic [dshot_pkg::THR_CLAMP_W-1:0] ceil_ff;
   logic [dshot_pkg::PAUSE_W-1:0]     pause_ff;

   // Frame shifter
   logic                              busy_ff, busy_in;
   logic [dshot_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [dshot_pkg::FRAME_BITS-1:0]  frame_ff, frame_in;

   // Output stage
   logic                              out_valid_ff, out_valid_in;
   logic                              out_first_level_ff, out_first_level_in;
   logic [dshot_pkg::HIGH_W-1:0]      out_first_dur_ff, out_first_dur_in;
   logic [dshot_pkg::LOW_W-1:0]       out_second_dur_ff, out_second_dur_in;
   logic                              out_last_ff, out_last_in;

   logic                              advance;
   logic                              emit;
   logic                              pause_item;
   logic                              accept;
   logic [5:0]                        bit_high;
   logic [6:0]                        bit_low;
   dshot_pkg::timing_type             timing;

   // Handshake control
   assign advance    = !out_valid_ff || !rsp_stall;
   assign emit       = busy_ff && advance;
   assign pause_item = count_ff[dshot_pkg::CNT_W-1];
   assign req_stall  = busy_ff && !(emit && pause_item);
   assign accept     = req_valid && !req_stall;

   // Pulse timing for the current bit
   always_comb begin
      timing   = dshot_pkg::rate_timing(mode_ff);
      bit_high = frame_ff[dshot_pkg::FRAME_BITS-1] ? timing.one_high : timing.zero_high;
      bit_low  = timing.period - {1'b0, bit_high};
   end

   // Next state of the frame shifter and output stage
   always_comb begin
      busy_in            = busy_ff;
      count_in           = count_ff;
      frame_in           = frame_ff;
      out_valid_in       = out_valid_ff;
      out_first_level_in = out_first_level_ff;
      out_first_dur_in   = out_first_dur_ff;
      out_second_dur_in  = out_second_dur_ff;
      out_last_in        = out_last_ff;

      if (advance) begin
         out_valid_in = emit;
      end

      if (emit) begin
         if (pause_item) begin
            out_first_level_in = 1'b0;
            out_first_dur_in   = pause_ff;
            out_second_dur_in  = '0;
            out_last_in        = 1'b1;
            busy_in            = 1'b0;
         end else begin
            out_first_level_in = 1'b1;
            out_first_dur_in   = {9'd0, bit_high};
            out_second_dur_in  = bit_low[dshot_pkg::LOW_W-1:0];
            out_last_in        = 1'b0;
            frame_in           = {frame_ff[dshot_pkg::FRAME_BITS-2:0], 1'b0};
            count_in           = count_ff + 5'd1;
         end
      end

      if (accept) begin
         busy_in  = 1'b1;
         count_in = '0;
         frame_in = dshot_pkg::encode_frame(req_throttle, req_telemetry_request,
                                            floor_ff, ceil_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         mode_ff      <= dshot_pkg::RESET_MODE;
         floor_ff     <= dshot_pkg::RESET_FLOOR;
         ceil_ff      <= dshot_pkg::RESET_CEILING;
         pause_ff     <= dshot_pkg::RESET_PAUSE;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               dshot_pkg::CSR_BIT_RATE_MODE:    mode_ff  <= csr_data[dshot_pkg::MODE_W-1:0];
               dshot_pkg::CSR_THROTTLE_FLOOR:   floor_ff <= csr_data[dshot_pkg::THR_CLAMP_W-1:0];
               dshot_pkg::CSR_THROTTLE_CEILING: ceil_ff  <= csr_data[dshot_pkg::THR_CLAMP_W-1:0];
               dshot_pkg::CSR_PAUSE_TICKS:      pause_ff <= csr_data[dshot_pkg::PAUSE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      frame_ff           <= frame_in;
      out_first_level_ff <= out_first_level_in;
      out_first_dur_ff   <= out_first_dur_in;
      out_second_dur_ff  <= out_second_dur_in;
      out_last_ff        <= out_last_in;
   end

   // Response outputs
   assign rsp_valid           = out_valid_ff;
   assign rsp_first_level     = out_first_level_ff;
   assign rsp_first_duration  = out_first_dur_ff;
   assign rsp_second_level    = 1'b0;
   assign rsp_second_duration = out_second_dur_ff;
   assign rsp_last            = out_last_ff;

endmodule
